FILE: rtl/ncc_pkg.sv
// shared constants, codes and types of the normalized cross correlation block
package ncc_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int MAX_SAMPLES  = 1024;
   localparam int ADDR_BITS    = $clog2(MAX_SAMPLES);
   localparam int LEN_BITS     = ADDR_BITS + 1;
   localparam int SUM1_BITS    = SAMPLE_BITS + ADDR_BITS + 1;
   localparam int PROD_BITS    = 2 * SAMPLE_BITS;
   localparam int SUM2_BITS    = PROD_BITS + ADDR_BITS;
   localparam int MID_BITS     = 2 * SUM1_BITS + 2;
   localparam int WIDE_BITS    = 2 * MID_BITS + 24;
   localparam int COEF_BITS    = 16;
   localparam int Q_BITS       = 16;
   localparam int QIDX_BITS    = $clog2(Q_BITS);
   localparam int OPC_BITS     = 2;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [OPC_BITS-1:0] OP_LOAD_FIXED  = 2'd0;
   localparam logic [OPC_BITS-1:0] OP_LOAD_MOVING = 2'd1;
   localparam logic [OPC_BITS-1:0] OP_COMPUTE     = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIXED_LEN  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MOVING_LEN = 2'd1;

   localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_SAMPLES);

   typedef struct packed {
      logic                 start;
      logic                 neg;
      logic [WIDE_BITS-1:0] mcand;
      logic [MID_BITS-1:0]  mplier;
   } ncc_mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [WIDE_BITS-1:0] prod;
   } ncc_mul_rsp_type;

endpackage

FILE: rtl/normalized_cross_correlation_top.sv
// top level: trace memories, window accumulation and coefficient sequencer
//
// channel   ports                          handshake
// request   start/busy, req_*              taken when start high and busy low
// response  rsp_valid, rsp_*               one-cycle strobe, no back-pressure
// config    csr_valid/csr_ready, csr_*     written when valid and ready
//
// load beats write one trace memory entry, busy stays low
// a compute beat walks the window one pair per cycle through the memory read
// ports, then runs eight serial products and a 16-step rounding search; a zero
// variance skips the last two products and the search
// the result strobe rises as busy falls
// reset is synchronous; trace memories keep their contents and need no clearing
module normalized_cross_correlation_top
   import ncc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [OPC_BITS-1:0]         req_opcode,
   input  logic [ADDR_BITS-1:0]        req_sample_index,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_value,
   input  logic [ADDR_BITS-1:0]        req_lag,
   output logic                        rsp_valid,
   output logic [ADDR_BITS-1:0]        rsp_lag_echo,
   output logic signed [SUM2_BITS-1:0] rsp_raw_sum,
   output logic signed [COEF_BITS-1:0] rsp_coefficient,
   output logic                        rsp_degenerate,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_BITS-1:0]     csr_index,
   input  logic [LEN_BITS-1:0]         csr_wdata
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ACC   = 7'b0000010,
      S_MUL   = 7'b0000100,
      S_MWAIT = 7'b0001000,
      S_SRCH  = 7'b0010000,
      S_SWAIT = 7'b0100000,
      S_DONE  = 7'b1000000
   } ncc_state_type;

   ncc_state_type state_ff, state_in;

   logic [LEN_BITS-1:0] fixed_len_ff;
   logic [LEN_BITS-1:0] moving_len_ff;

   logic signed [SAMPLE_BITS-1:0] fix_mem [MAX_SAMPLES];
   logic signed [SAMPLE_BITS-1:0] mov_mem [MAX_SAMPLES];
   logic signed [SAMPLE_BITS-1:0] fix_rd_ff;
   logic signed [SAMPLE_BITS-1:0] mov_rd_ff;

   logic accept;
   logic load_fix;
   logic load_mov;
   logic go_compute;

   logic [ADDR_BITS-1:0] lag_ff;
   logic [LEN_BITS-1:0]  n_ff;
   logic [LEN_BITS-1:0]  nf_ff;
   logic [LEN_BITS-1:0]  k_ff;
   logic [LEN_BITS-1:0]  fix_addr;
   logic                 issue;
   logic                 acc_done;

   logic                          v1_ff;
   logic                          inr1_ff;
   logic                          v2_ff;
   logic signed [SAMPLE_BITS-1:0] x1;
   logic signed [SAMPLE_BITS-1:0] xd_ff;
   logic signed [SAMPLE_BITS-1:0] yd_ff;
   logic signed [PROD_BITS-1:0]   pxx_ff;
   logic signed [PROD_BITS-1:0]   pyy_ff;
   logic signed [PROD_BITS-1:0]   pxy_ff;

   logic signed [SUM1_BITS-1:0] s1_ff;
   logic signed [SUM1_BITS-1:0] s2_ff;
   logic signed [SUM2_BITS-1:0] s11_ff;
   logic signed [SUM2_BITS-1:0] s22_ff;
   logic signed [SUM2_BITS-1:0] s12_ff;

   logic [2:0]                 step_ff;
   logic signed [MID_BITS-1:0] t0_ff;
   logic signed [MID_BITS-1:0] num_ff;
   logic signed [MID_BITS-1:0] va_ff;
   logic signed [MID_BITS-1:0] vb_ff;
   logic [WIDE_BITS-1:0]       ab_ff;
   logic [WIDE_BITS-1:0]       lim_ff;
   logic [Q_BITS-1:0]          q_ff;
   logic [QIDX_BITS-1:0]       bit_ff;
   logic                       degen_ff;

   logic signed [MID_BITS-1:0] opa;
   logic signed [MID_BITS-1:0] opb;
   logic [MID_BITS-1:0]        maga;
   logic [MID_BITS-1:0]        magb;
   logic [Q_BITS-1:0]          cand;
   logic [Q_BITS:0]            tval;
   logic [2*Q_BITS+1:0]        tsq;
   logic signed [MID_BITS-1:0] prod_mid;
   logic signed [MID_BITS-1:0] diff;

   logic                       rsp_valid_ff;
   logic [ADDR_BITS-1:0]       rsp_lag_ff;
   logic signed [SUM2_BITS-1:0] rsp_raw_ff;
   logic signed [COEF_BITS-1:0] rsp_coef_ff;
   logic                       rsp_degen_ff;

   ncc_mul_req_type mul_req;
   ncc_mul_rsp_type mul_rsp;

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign load_fix   = accept && (req_opcode == OP_LOAD_FIXED);
   assign load_mov   = accept && (req_opcode == OP_LOAD_MOVING);
   assign go_compute = accept && (req_opcode == OP_COMPUTE);
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_len_ff  <= LEN_MAX;
         moving_len_ff <= LEN_MAX;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FIXED_LEN:  fixed_len_ff  <= csr_wdata;
            CSR_MOVING_LEN: moving_len_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // trace memories
   assign fix_addr = LEN_BITS'(lag_ff) + k_ff;
   assign issue    = (state_ff == S_ACC) && (k_ff < n_ff);

   always_ff @(posedge clock) begin
      if (load_fix) begin
         fix_mem[req_sample_index] <= req_sample_value;
      end
      if (issue) begin
         fix_rd_ff <= fix_mem[fix_addr[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (load_mov) begin
         mov_mem[req_sample_index] <= req_sample_value;
      end
      if (issue) begin
         mov_rd_ff <= mov_mem[k_ff[ADDR_BITS-1:0]];
      end
   end

   // window pipeline: read, products, accumulate
   assign x1       = inr1_ff ? fix_rd_ff : '0;
   assign acc_done = (state_ff == S_ACC) && (k_ff == n_ff) && !v1_ff && !v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go_compute) begin
         lag_ff <= req_lag;
         n_ff   <= (moving_len_ff > LEN_MAX) ? LEN_MAX : moving_len_ff;
         nf_ff  <= (fixed_len_ff > LEN_MAX) ? LEN_MAX : fixed_len_ff;
         k_ff   <= '0;
      end else if (issue) begin
         k_ff <= k_ff + LEN_BITS'(1);
      end
      inr1_ff <= fix_addr < nf_ff;
      xd_ff   <= x1;
      yd_ff   <= mov_rd_ff;
      pxx_ff  <= x1 * x1;
      pyy_ff  <= mov_rd_ff * mov_rd_ff;
      pxy_ff  <= x1 * mov_rd_ff;
      if (go_compute) begin
         s1_ff  <= '0;
         s2_ff  <= '0;
         s11_ff <= '0;
         s22_ff <= '0;
         s12_ff <= '0;
      end else if (v2_ff) begin
         s1_ff  <= s1_ff + SUM1_BITS'(xd_ff);
         s2_ff  <= s2_ff + SUM1_BITS'(yd_ff);
         s11_ff <= s11_ff + SUM2_BITS'(pxx_ff);
         s22_ff <= s22_ff + SUM2_BITS'(pyy_ff);
         s12_ff <= s12_ff + SUM2_BITS'(pxy_ff);
      end
   end

   // multiplier operands
   always_comb begin
      case (step_ff)
         3'd0: begin
            opa = MID_BITS'(s12_ff);
            opb = MID_BITS'(n_ff);
         end
         3'd1: begin
            opa = MID_BITS'(s1_ff);
            opb = MID_BITS'(s2_ff);
         end
         3'd2: begin
            opa = MID_BITS'(s11_ff);
            opb = MID_BITS'(n_ff);
         end
         3'd3: begin
            opa = MID_BITS'(s1_ff);
            opb = MID_BITS'(s1_ff);
         end
         3'd4: begin
            opa = MID_BITS'(s22_ff);
            opb = MID_BITS'(n_ff);
         end
         3'd5: begin
            opa = MID_BITS'(s2_ff);
            opb = MID_BITS'(s2_ff);
         end
         3'd6: begin
            opa = va_ff;
            opb = vb_ff;
         end
         default: begin
            opa = num_ff;
            opb = num_ff;
         end
      endcase
   end

   assign maga = opa[MID_BITS-1] ? MID_BITS'(-opa) : MID_BITS'(opa);
   assign magb = opb[MID_BITS-1] ? MID_BITS'(-opb) : MID_BITS'(opb);
   assign cand = q_ff | (Q_BITS'(1) << bit_ff);
   assign tval = {cand, 1'b0} - (Q_BITS + 1)'(1);
   assign tsq  = tval * tval;

   always_comb begin
      mul_req.start  = 1'b0;
      mul_req.neg    = 1'b0;
      mul_req.mcand  = WIDE_BITS'(maga);
      mul_req.mplier = magb;
      if (state_ff == S_MUL) begin
         mul_req.start = 1'b1;
         mul_req.neg   = opa[MID_BITS-1] ^ opb[MID_BITS-1];
      end else if (state_ff == S_SRCH) begin
         mul_req.start  = 1'b1;
         mul_req.mcand  = ab_ff;
         mul_req.mplier = MID_BITS'(tsq);
      end
   end

   ncc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign prod_mid = mul_rsp.prod[MID_BITS-1:0];
   assign diff     = t0_ff - prod_mid;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (go_compute) state_in = S_ACC;
         S_ACC:   if (acc_done) state_in = S_MUL;
         S_MUL:   state_in = S_MWAIT;
         S_MWAIT: begin
            if (mul_rsp.done) begin
               if (step_ff == 3'd5 && (va_ff == '0 || diff == '0)) begin
                  state_in = S_DONE;
               end else if (step_ff == 3'd7) begin
                  state_in = S_SRCH;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_SRCH:  state_in = S_SWAIT;
         S_SWAIT: begin
            if (mul_rsp.done) begin
               state_in = (bit_ff == '0) ? S_DONE : S_SRCH;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (acc_done) begin
         step_ff  <= '0;
         degen_ff <= 1'b0;
         q_ff     <= '0;
         bit_ff   <= QIDX_BITS'(Q_BITS - 1);
      end
      if (state_ff == S_MWAIT && mul_rsp.done) begin
         step_ff <= step_ff + 3'd1;
         case (step_ff) inside
            3'd0, 3'd2, 3'd4: t0_ff <= prod_mid;
            3'd1: num_ff <= diff;
            3'd3: va_ff  <= diff;
            3'd5: begin
               vb_ff    <= diff;
               degen_ff <= (va_ff == '0) || (diff == '0);
            end
            3'd6: ab_ff  <= mul_rsp.prod;
            default: lim_ff <= {mul_rsp.prod[WIDE_BITS-33:0], 32'b0};
         endcase
      end
      if (state_ff == S_SWAIT && mul_rsp.done) begin
         if (mul_rsp.prod <= lim_ff) begin
            q_ff <= cand;
         end
         bit_ff <= bit_ff - QIDX_BITS'(1);
      end
      if (state_ff == S_DONE) begin
         rsp_lag_ff   <= lag_ff;
         rsp_raw_ff   <= s12_ff;
         rsp_degen_ff <= degen_ff;
         if (degen_ff) begin
            rsp_coef_ff <= '0;
         end else if (num_ff[MID_BITS-1]) begin
            rsp_coef_ff <= COEF_BITS'(-q_ff);
         end else if (q_ff[Q_BITS-1]) begin
            rsp_coef_ff <= {1'b0, {(COEF_BITS-1){1'b1}}};
         end else begin
            rsp_coef_ff <= COEF_BITS'(q_ff);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lag_echo    = rsp_lag_ff;
   assign rsp_raw_sum     = rsp_raw_ff;
   assign rsp_coefficient = rsp_coef_ff;
   assign rsp_degenerate  = rsp_degen_ff;

endmodule

FILE: rtl/ncc_mul.sv
// serial shift-add multiplier for the wide post-accumulation products
module ncc_mul
   import ncc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ncc_mul_req_type mul_req,
   output ncc_mul_rsp_type mul_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic                 neg_ff;
   logic [WIDE_BITS-1:0] mc_ff;
   logic [MID_BITS-1:0]  mr_ff;
   logic [WIDE_BITS-1:0] acc_ff;
   logic [WIDE_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && mr_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         mc_ff  <= mul_req.mcand;
         mr_ff  <= mul_req.mplier;
         neg_ff <= mul_req.neg;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (mr_ff == '0) begin
            prod_ff <= neg_ff ? (~acc_ff + WIDE_BITS'(1)) : acc_ff;
         end else begin
            if (mr_ff[0]) begin
               acc_ff <= acc_ff + mc_ff;
            end
            mc_ff <= {mc_ff[WIDE_BITS-2:0], 1'b0};
            mr_ff <= {1'b0, mr_ff[MID_BITS-1:1]};
         end
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = prod_ff;

endmodule

FILE: tb/tb_top.sv
// testbench for the normalized cross correlation block: scoreboard, stimulus and checks
`timescale 1ns / 100ps

import ncc_pkg::*;

class ncc_scoreboard;
   typedef logic signed [255:0] wide_type;
   typedef struct {
      logic [ADDR_BITS-1:0] lag;
      logic [SUM2_BITS-1:0] raw_sum;
      logic [COEF_BITS-1:0] coefficient;
      logic                 degenerate;
   } ncc_result_type;

   logic signed [SAMPLE_BITS-1:0] fixed_mem [MAX_SAMPLES];
   logic signed [SAMPLE_BITS-1:0] moving_mem [MAX_SAMPLES];
   logic [LEN_BITS-1:0] fixed_len = LEN_MAX;
   logic [LEN_BITS-1:0] moving_len = LEN_MAX;
   ncc_result_type expected_q [$];
   int errors = 0;

   function void write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [LEN_BITS-1:0] v);
      if (idx == CSR_FIXED_LEN) fixed_len = v;
      else if (idx == CSR_MOVING_LEN) moving_len = v;
   endfunction

   function int clamp_len(logic [LEN_BITS-1:0] v);
      return (v > MAX_SAMPLES) ? MAX_SAMPLES : int'(v);
   endfunction

   function void note(logic [OPC_BITS-1:0] op, logic [ADDR_BITS-1:0] idx,
                      logic signed [SAMPLE_BITS-1:0] val, logic [ADDR_BITS-1:0] lag);
      int n, nf, p;
      wide_type x, y, s1, s2, s11, s22, s12, wn, num, a, b, ab, lim, lhs;
      longint lo, hi, mid, t;
      bit neg;
      ncc_result_type r;
      if (op == OP_LOAD_FIXED) begin
         fixed_mem[idx] = val;
         return;
      end
      if (op == OP_LOAD_MOVING) begin
         moving_mem[idx] = val;
         return;
      end
      if (op != OP_COMPUTE) return;
      n = clamp_len(moving_len);
      nf = clamp_len(fixed_len);
      s1 = 0; s2 = 0; s11 = 0; s22 = 0; s12 = 0;
      for (int k = 0; k < n; k++) begin
         p = int'(lag) + k;
         if (p < nf && p < MAX_SAMPLES) x = fixed_mem[p];
         else x = 0;
         y = moving_mem[k];
         s1 += x; s2 += y; s11 += x * x; s22 += y * y; s12 += x * y;
      end
      wn = n;
      num = wn * s12 - s1 * s2;
      a = wn * s11 - s1 * s1;
      b = wn * s22 - s2 * s2;
      r.lag = lag;
      r.raw_sum = s12[SUM2_BITS-1:0];
      r.coefficient = '0;
      r.degenerate = 1'b0;
      if (a == 0 || b == 0) begin
         r.degenerate = 1'b1;
      end else begin
         neg = num < 0;
         if (neg) num = -num;
         ab = a * b;
         lim = (num * num) <<< 32;
         lo = 0;
         hi = 32768;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            lhs = wide_type'(t * t) * ab;
            if (lhs <= lim) lo = mid;
            else hi = mid - 1;
         end
         if (neg) r.coefficient = COEF_BITS'(-lo);
         else r.coefficient = COEF_BITS'((lo > 32767) ? 32767 : lo);
      end
      expected_q.push_back(r);
   endfunction

   function void check(logic [ADDR_BITS-1:0] lag, logic [SUM2_BITS-1:0] raw_sum,
                       logic [COEF_BITS-1:0] coefficient, logic degenerate);
      ncc_result_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result beat lag %0d", $time, lag);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (lag !== e.lag) begin
         $display("%0t: lag_echo expected %0d actual %0d", $time, e.lag, lag);
         errors++;
      end
      if (raw_sum !== e.raw_sum) begin
         $display("%0t: raw_sum expected %h actual %h", $time, e.raw_sum, raw_sum);
         errors++;
      end
      if (coefficient !== e.coefficient) begin
         $display("%0t: coefficient expected %0d actual %0d", $time,
                  $signed(e.coefficient), $signed(coefficient));
         errors++;
      end
      if (degenerate !== e.degenerate) begin
         $display("%0t: degenerate expected %0b actual %0b", $time, e.degenerate, degenerate);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam logic [OPC_BITS-1:0]     OP_UNUSED  = 2'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE2 = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE3 = 2'd3;
   localparam int                      PRELOAD    = 64;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [OPC_BITS-1:0]           req_opcode = OP_LOAD_FIXED;
   logic [ADDR_BITS-1:0]          req_sample_index = '0;
   logic signed [SAMPLE_BITS-1:0] req_sample_value = '0;
   logic [ADDR_BITS-1:0]          req_lag = '0;
   logic                          rsp_valid;
   logic [ADDR_BITS-1:0]          rsp_lag_echo;
   logic signed [SUM2_BITS-1:0]   rsp_raw_sum;
   logic signed [COEF_BITS-1:0]   rsp_coefficient;
   logic                          rsp_degenerate;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index = '0;
   logic [LEN_BITS-1:0]           csr_wdata = '0;

   ncc_scoreboard sb = new();
   int burst_left = 0;
   longint cycles = 0;

   normalized_cross_correlation_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check(rsp_lag_echo, rsp_raw_sum, rsp_coefficient, rsp_degenerate);
   end

   task automatic send(logic [OPC_BITS-1:0] op, logic [ADDR_BITS-1:0] idx,
                       logic signed [SAMPLE_BITS-1:0] val, logic [ADDR_BITS-1:0] lag);
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_sample_index = idx;
      req_sample_value = val;
      req_lag = lag;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note(op, idx, val, lag);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (sb.expected_q.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [LEN_BITS-1:0] v);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = v;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_lengths(logic [LEN_BITS-1:0] fl, logic [LEN_BITS-1:0] ml);
      drain();
      csr_write(CSR_FIXED_LEN, fl);
      csr_write(CSR_MOVING_LEN, ml);
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return -24'sd8388608;
         1: return 24'sd8388607;
         2: return SAMPLE_BITS'($signed($urandom_range(0, 16)) - 8);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   initial begin
      int fl, ml, nf;
      logic [OPC_BITS-1:0] op;
      logic [ADDR_BITS-1:0] lag;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // windows stay inside the preloaded entries or past the fixed length
      for (int i = 0; i < PRELOAD; i++) begin
         send(OP_LOAD_FIXED, ADDR_BITS'(i), rand_sample(), '0);
         send(OP_LOAD_MOVING, ADDR_BITS'(i), rand_sample(), '0);
      end

      // directed: extreme lags, exact and inverse match
      set_lengths(11'd2047, 11'd40);
      send(OP_LOAD_FIXED, 10'd1023, rand_sample(), '0);
      send(OP_COMPUTE, '0, '0, 10'd0);
      send(OP_COMPUTE, '0, '0, 10'd1023);
      set_lengths(11'd8, 11'd4);
      send(OP_LOAD_MOVING, 10'd0, -24'sd8388608, '0);
      send(OP_LOAD_MOVING, 10'd1, 24'sd8388607, '0);
      send(OP_LOAD_MOVING, 10'd2, 24'sd300, '0);
      send(OP_LOAD_MOVING, 10'd3, -24'sd7, '0);
      send(OP_LOAD_FIXED, 10'd0, -24'sd8388608, '0);
      send(OP_LOAD_FIXED, 10'd1, 24'sd8388607, '0);
      send(OP_LOAD_FIXED, 10'd2, 24'sd300, '0);
      send(OP_LOAD_FIXED, 10'd3, -24'sd7, '0);
      send(OP_LOAD_FIXED, 10'd4, 24'sd8388607, '0);
      send(OP_LOAD_FIXED, 10'd5, -24'sd8388607, '0);
      send(OP_LOAD_FIXED, 10'd6, -24'sd300, '0);
      send(OP_LOAD_FIXED, 10'd7, 24'sd7, '0);
      send(OP_COMPUTE, '0, '0, 10'd0);
      send(OP_COMPUTE, '0, '0, 10'd4);
      send(OP_COMPUTE, '0, '0, 10'd6);
      send(OP_COMPUTE, '0, '0, 10'd900);
      send(OP_UNUSED, 10'd5, 24'sd1, 10'd5);
      set_lengths(11'd8, 11'd1);
      send(OP_COMPUTE, '0, '0, 10'd2);
      set_lengths(11'd0, 11'd4);
      send(OP_COMPUTE, '0, '0, 10'd0);
      set_lengths(11'd2047, 11'd0);
      send(OP_COMPUTE, '0, '0, 10'd3);
      set_lengths(11'd5, 11'd6);
      csr_write(CSR_SPARE2, 11'h7ff);
      csr_write(CSR_SPARE3, 11'h555);
      send(OP_COMPUTE, '0, '0, 10'd1);

      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 7))
            0: fl = 0;
            1: fl = 1;
            2: fl = 1024;
            3: fl = 2047;
            default: fl = $urandom_range(1, 64);
         endcase
         if (ph == 2) ml = 0;
         else if (ph == 5) ml = PRELOAD;
         else ml = $urandom_range(1, 40);
         set_lengths(LEN_BITS'(fl), LEN_BITS'(ml));
         nf = (fl > MAX_SAMPLES) ? MAX_SAMPLES : fl;
         for (int i = 0; i < 50; i++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7: op = OP_COMPUTE;
               8, 9, 10, 11, 12: op = OP_LOAD_FIXED;
               13, 14, 15, 16, 17: op = OP_LOAD_MOVING;
               default: op = OP_UNUSED;
            endcase
            if (nf < MAX_SAMPLES && $urandom_range(0, 3) == 0)
               lag = ADDR_BITS'($urandom_range(nf, MAX_SAMPLES - 1));
            else
               lag = ADDR_BITS'($urandom_range(0, PRELOAD - ml));
            send(op, ADDR_BITS'($urandom), rand_sample(), lag);
         end
      end

      drain();
      repeat (2500) @(negedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end
endmodule
